// File: src/ricl_pkg.sv
// Shared types, codes and beat layout for the run interval calibration lookup.
package ricl_pkg;

	// Request kinds carried on the slave-side tuser
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_DET = 2'd1;
	localparam logic [1:0] ST_NO_HIT  = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	// Largest distance that still makes an entry a usable nearest match
	localparam int          FIELD_RUN_W  = 20;
	localparam logic [19:0] MAX_DISTANCE = 20'd999999;

	// Field widths
	localparam int DET_W    = 2;
	localparam int RING_W   = 7;
	localparam int FACTOR_W = 24;
	localparam int STATUS_W = 2;

	// Slave-side tdata layout, lowest bit first
	localparam int DET_LSB    = 0;
	localparam int RING_LSB   = DET_LSB + DET_W;
	localparam int START_LSB  = RING_LSB + RING_W;
	localparam int END_LSB    = START_LSB + FIELD_RUN_W;
	localparam int FACTOR_LSB = END_LSB + FIELD_RUN_W;
	localparam int RUN_LSB    = FACTOR_LSB + FACTOR_W;
	localparam int S_DATA_W   = 96;
	localparam int S_USER_W   = 1;
	localparam int M_DATA_W   = 24;
	localparam int M_USER_W   = 3;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_COUNT,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_req;
		logic cnt_read;
		logic scan_en;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic bad_req;
		logic scan_done;
		logic out_free;
	} sts_t;

endpackage

// File: src/ricl_ctrl.sv
// Controller state machine that sequences count read, table scan and result.
module ricl_ctrl
	import ricl_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   s_tvalid,
	output logic   s_tready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q;
	state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_nxt = S_COUNT;
			end
			S_COUNT: begin
				state_nxt = sts.bad_req ? S_FINISH : S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_done) state_nxt = S_DRAIN;
			end
			S_DRAIN: begin
				state_nxt = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		s_tready     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			S_IDLE: begin
				s_tready     = 1'b1;
				cmd.load_req = s_tvalid;
			end
			S_COUNT: begin
				cmd.cnt_read = 1'b1;
			end
			S_SCAN: begin
				cmd.scan_en = !sts.scan_done;
			end
			S_DRAIN: begin
			end
			S_FINISH: begin
				cmd.finish = sts.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: src/ricl_datapath.sv
// Datapath: request registers, table memories, scan pipeline and result register.
module ricl_datapath
	import ricl_pkg::*;
#(
	parameter int RINGS_PER_DETECTOR = 128,
	parameter int ENTRIES_PER_RING   = 64,
	parameter int RUN_BITS           = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic [S_USER_W-1:0] s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,
	output logic [M_USER_W-1:0] m_tuser
);

	localparam int KW     = (RUN_BITS < FIELD_RUN_W) ? RUN_BITS : FIELD_RUN_W;
	localparam int TABLES = 2 * RINGS_PER_DETECTOR;
	localparam int TW     = (TABLES > 1) ? $clog2(TABLES) : 1;
	localparam int DEPTH  = TABLES * ENTRIES_PER_RING;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW     = $clog2(ENTRIES_PER_RING + 1);
	localparam int WW     = 2 * KW + FACTOR_W;

	// Request registers
	logic                req_q;
	logic                bad_q;
	logic [TW-1:0]       tbl_q;
	logic [KW-1:0]       s_in_q;
	logic [KW-1:0]       e_in_q;
	logic [FACTOR_W-1:0] f_in_q;
	logic [KW-1:0]       run_q;

	logic [DET_W-1:0]  in_det;
	logic [RING_W-1:0] in_ring;
	logic              in_bad;
	logic [TW-1:0]     in_tbl;

	assign in_det  = s_tdata[DET_LSB +: DET_W];
	assign in_ring = s_tdata[RING_LSB +: RING_W];
	assign in_bad  = (in_det > 2'd1) ||
	                 ({2'b00, in_ring} >= 9'(RINGS_PER_DETECTOR));
	assign in_tbl  = in_det[0] ? (TW'(RINGS_PER_DETECTOR) + TW'(in_ring)) : TW'(in_ring);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= REQ_INSERT;
			bad_q <= 1'b0;
		end else if (cmd.load_req) begin
			req_q <= s_tuser[0];
			bad_q <= in_bad;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			tbl_q  <= in_tbl;
			s_in_q <= s_tdata[START_LSB +: KW];
			e_in_q <= s_tdata[END_LSB +: KW];
			f_in_q <= s_tdata[FACTOR_LSB +: FACTOR_W];
			run_q  <= s_tdata[RUN_LSB +: KW];
		end
	end

	// Entry counts per table: a memory plus a valid bit per table cleared at reset
	logic [CW-1:0]     cnt_mem [TABLES];
	logic [TABLES-1:0] cnt_vld_q;
	logic [CW-1:0]     cnt_rd_q;
	logic              cnt_vld_rd_q;
	logic [AW-1:0]     base_q;
	logic [CW-1:0]     n_ent;
	logic              cnt_we;

	assign n_ent = cnt_vld_rd_q ? cnt_rd_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
		end else if (cnt_we) begin
			cnt_vld_q[tbl_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[tbl_q] <= n_ent + CW'(1);
		end
		if (cmd.cnt_read) begin
			cnt_rd_q     <= cnt_mem[tbl_q];
			cnt_vld_rd_q <= cnt_vld_q[tbl_q];
			base_q       <= AW'(tbl_q) * AW'(ENTRIES_PER_RING);
		end
	end

	// Scan index
	logic [CW-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load_req) begin
			idx_q <= '0;
		end else if (cmd.scan_en) begin
			idx_q <= idx_q + CW'(1);
		end
	end

	// Entry memory: {factor, end, start}, one write and one registered read a cycle
	logic [WW-1:0] ent_mem [DEPTH];
	logic [WW-1:0] rd_word_s1;
	logic [CW-1:0] idx_s1;
	logic          v_s1;
	logic          ent_we;
	logic [AW-1:0] ent_waddr;

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_waddr] <= {f_in_q, e_in_q, s_in_q};
		end
		if (cmd.scan_en) begin
			rd_word_s1 <= ent_mem[base_q + AW'(idx_q)];
			idx_s1     <= idx_q;
		end
	end

	// Stage one: containment, distance and key match for the entry just read
	logic [KW-1:0]       st1_start;
	logic [KW-1:0]       st1_end;
	logic [KW-1:0]       d_start;
	logic [KW-1:0]       d_end;
	logic [KW-1:0]       d_min;

	assign st1_start = rd_word_s1[0 +: KW];
	assign st1_end   = rd_word_s1[KW +: KW];
	assign d_start   = (run_q >= st1_start) ? (run_q - st1_start) : (st1_start - run_q);
	assign d_end     = (run_q >= st1_end) ? (run_q - st1_end) : (st1_end - run_q);
	assign d_min     = (d_start < d_end) ? d_start : d_end;

	logic                v_s2;
	logic                ins_s2;
	logic                near_ok_s2;
	logic                match_s2;
	logic [KW-1:0]       dist_s2;
	logic [2*KW-1:0]     key_s2;
	logic [FACTOR_W-1:0] val_s2;
	logic [CW-1:0]       idx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			ins_s2     <= (run_q >= st1_start) && (run_q <= st1_end);
			near_ok_s2 <= (FIELD_RUN_W'(d_min) <= MAX_DISTANCE);
			match_s2   <= (st1_start == s_in_q) && (st1_end == e_in_q);
			dist_s2    <= d_min;
			key_s2     <= {st1_start, st1_end};
			val_s2     <= rd_word_s1[2*KW +: FACTOR_W];
			idx_s2     <= idx_s1;
		end
	end

	// Stage two: keep the best containing entry, the best nearest entry and the match
	logic                have_in_q;
	logic                have_near_q;
	logic                found_q;
	logic [2*KW-1:0]     in_key_q;
	logic [FACTOR_W-1:0] in_val_q;
	logic [2*KW-1:0]     near_key_q;
	logic [FACTOR_W-1:0] near_val_q;
	logic [KW-1:0]       best_q;
	logic [CW-1:0]       match_idx_q;
	logic                take_in;
	logic                take_near;

	assign take_in   = v_s2 && ins_s2 && (!have_in_q || (key_s2 < in_key_q));
	assign take_near = v_s2 && near_ok_s2 &&
	                   (!have_near_q || (dist_s2 < best_q) ||
	                    ((dist_s2 == best_q) && (near_key_q < key_s2)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_in_q   <= 1'b0;
			have_near_q <= 1'b0;
			found_q     <= 1'b0;
		end else if (cmd.load_req) begin
			have_in_q   <= 1'b0;
			have_near_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (take_in)            have_in_q   <= 1'b1;
			if (take_near)          have_near_q <= 1'b1;
			if (v_s2 && match_s2)   found_q     <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			in_key_q <= key_s2;
			in_val_q <= val_s2;
		end
		if (take_near) begin
			near_key_q <= key_s2;
			near_val_q <= val_s2;
			best_q     <= dist_s2;
		end
		if (v_s2 && match_s2) begin
			match_idx_q <= idx_s2;
		end
	end

	// Final decision, table update and result
	logic                room;
	logic [FACTOR_W-1:0] res_factor;
	logic [STATUS_W-1:0] res_status;
	logic                res_inside;

	assign room      = (n_ent < CW'(ENTRIES_PER_RING));
	assign ent_waddr = base_q + AW'(found_q ? match_idx_q : n_ent);

	always_comb begin
		ent_we     = 1'b0;
		cnt_we     = 1'b0;
		res_factor = '0;
		res_status = ST_OK;
		res_inside = 1'b0;
		priority if (bad_q) begin
			res_status = ST_BAD_DET;
		end else if (req_q == REQ_INSERT) begin
			if (found_q) begin
				ent_we = cmd.finish;
			end else if (room) begin
				ent_we = cmd.finish;
				cnt_we = cmd.finish;
			end else begin
				res_status = ST_FULL;
			end
		end else if (have_in_q) begin
			res_factor = in_val_q;
			res_inside = 1'b1;
		end else if (have_near_q) begin
			res_factor = near_val_q;
		end else begin
			res_status = ST_NO_HIT;
		end
	end

	// Result register
	logic                out_vld_q;
	logic [FACTOR_W-1:0] out_factor_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_inside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.finish) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_factor_q <= res_factor;
			out_status_q <= res_status;
			out_inside_q <= res_inside;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_factor_q;
	assign m_tuser  = {out_inside_q, out_status_q};

	// Status to the controller
	assign sts.bad_req   = bad_q;
	assign sts.scan_done = (idx_q >= n_ent);
	assign sts.out_free  = !out_vld_q || m_tready;

endmodule

// File: src/run_interval_calibration_lookup.sv
// Top level of the run interval calibration lookup.
// Keeps one table of run intervals per (detector, ring), each entry an interval
// (start, end) and a signed Q8.16 factor. A beat with tuser 0 inserts an interval,
// overwriting the factor of an entry with the same start and end; tuser 1 queries a
// run and returns the factor of the containing interval with the smallest key
// (start, then end), else that of the nearest interval within 999999 runs (ties
// to the larger key). One result beat is returned per request beat. For each
// request the table's entry count is read, then the table, of up to 64 entries,
// is walked one entry per cycle through the single read port of the entry
// memory, then the compare pipeline is emptied and the result is registered once
// the output is free; the next request beat is taken after that. A bad detector
// or ring skips the walk and gives its result after the count read.
// A new request is taken while a result waits.
module run_interval_calibration_lookup
	import ricl_pkg::*;
#(
	parameter int RINGS_PER_DETECTOR = 128,
	parameter int ENTRIES_PER_RING   = 64,
	parameter int RUN_BITS           = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// detector[1:0], ring_index[8:2], interval_start[28:9], interval_end[48:29],
	// factor_in[72:49], run_number[92:73], zero fill above
	input  logic [S_DATA_W-1:0] s_tdata,
	// req_type[0]
	input  logic [S_USER_W-1:0] s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// factor_out[23:0]
	output logic [M_DATA_W-1:0] m_tdata,
	// status[1:0], inside_interval[2]
	output logic [M_USER_W-1:0] m_tuser
);

	cmd_t cmd;
	sts_t sts;

	// Sequencing
	ricl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Tables, scan and result
	ricl_datapath #(
		.RINGS_PER_DETECTOR (RINGS_PER_DETECTOR),
		.ENTRIES_PER_RING   (ENTRIES_PER_RING),
		.RUN_BITS           (RUN_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
